[rtl/bbc_pkg.sv]
package bbc_pkg;

  // Register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INHALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXHALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LVL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LVL = 3'd4;

  localparam logic [15:0] PERIOD_RST  = 16'd6000;
  localparam logic [3:0]  INHALE_RST  = 4'd1;
  localparam logic [3:0]  EXHALE_RST  = 4'd2;
  localparam logic [7:0]  MIN_LVL_RST = 8'd80;
  localparam logic [7:0]  MAX_LVL_RST = 8'd120;
  localparam logic [7:0]  LAST_RST    = 8'd255;

  // Easing curve codes
  localparam logic [3:0] CURVE_LINEAR      = 4'd0;
  localparam logic [3:0] CURVE_QUAD_IN     = 4'd1;
  localparam logic [3:0] CURVE_QUAD_OUT    = 4'd2;
  localparam logic [3:0] CURVE_QUAD_INOUT  = 4'd3;
  localparam logic [3:0] CURVE_CUBIC_IN    = 4'd4;
  localparam logic [3:0] CURVE_CUBIC_OUT   = 4'd5;
  localparam logic [3:0] CURVE_CUBIC_INOUT = 4'd6;
  localparam logic [3:0] CURVE_SINE_IN     = 4'd7;
  localparam logic [3:0] CURVE_SINE_OUT    = 4'd8;
  localparam logic [3:0] CURVE_SINE_INOUT  = 4'd9;

  // Fixed-point phase constants (1.0 == 1024)
  localparam logic [10:0] ONE_Q      = 11'd1024;
  localparam logic [10:0] INHALE_END = 11'd410;
  localparam logic [10:0] HOLD_END   = 11'd512;

  // Inhale sub-phase p * 1024 / 410 as a reciprocal multiply, exact for p < 410
  localparam logic [20:0] INHALE_RECIP = 21'd327361;
  localparam int unsigned INHALE_SHIFT = 17;

  // Restoring divider: remainder starts below the divisor, ten quotient bits
  localparam int unsigned QUO_W     = 10;
  localparam int unsigned DIV_STEPS = QUO_W;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_PHASE,
    OP_XDIV,
    OP_SQ,
    OP_CUBE,
    OP_EASE,
    OP_MAP,
    OP_LEVEL
  } bbc_op_e;

  typedef struct packed {
    bbc_op_e op;
  } bbc_cmd_t;

  typedef struct packed {
    logic inhale;
    logic hold;
  } bbc_status_t;

endpackage

[rtl/bbc_in_if.sv]
interface bbc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink (input valid, input elapsed_ms, output ready);
endinterface

[rtl/bbc_out_if.sv]
interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       write_strobe;

  modport source (output valid, output level, output write_strobe, input ready);
  modport sink (input valid, input level, input write_strobe, output ready);
endinterface

[rtl/bbc_ctrl.sv]
module bbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bbc_pkg::bbc_status_t status_i,
  output bbc_pkg::bbc_cmd_t    cmd_o
);
  import bbc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_DIV1  = 9'b0_0000_0010,
    S_PHASE = 9'b0_0000_0100,
    S_XSET  = 9'b0_0000_1000,
    S_SQ    = 9'b0_0001_0000,
    S_CUBE  = 9'b0_0010_0000,
    S_EASE  = 9'b0_0100_0000,
    S_MAP   = 9'b0_1000_0000,
    S_LEVEL = 9'b1_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             last_step;

  assign last_step = (cnt_q == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cnt_d    = '0;
          state_d  = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (last_step) state_d = S_PHASE;
      end
      S_PHASE: begin
        cmd_o.op = OP_PHASE;
        cnt_d    = '0;
        if (status_i.inhale) begin
          state_d = S_XSET;
        end else if (status_i.hold) begin
          state_d = S_MAP;
        end else begin
          state_d = S_SQ;
        end
      end
      S_XSET: begin
        cmd_o.op = OP_XDIV;
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.op = OP_CUBE;
        state_d  = S_EASE;
      end
      S_EASE: begin
        cmd_o.op = OP_EASE;
        state_d  = S_MAP;
      end
      S_MAP: begin
        cmd_o.op = OP_MAP;
        state_d  = S_LEVEL;
      end
      S_LEVEL: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_LEVEL;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/bbc_dpath.sv]
module bbc_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bbc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [15:0]                       elapsed_ms_i,
  input  bbc_pkg::bbc_cmd_t                 cmd_i,
  output bbc_pkg::bbc_status_t              status_o,
  output logic [7:0]                        level_o,
  output logic                              write_strobe_o
);
  import bbc_pkg::*;

  // configuration and write history
  logic [15:0] period_q;
  logic [3:0]  inhale_curve_q;
  logic [3:0]  exhale_curve_q;
  logic [7:0]  min_level_q;
  logic [7:0]  max_level_q;
  logic [7:0]  last_q;

  // working registers
  logic             zero_q, sat_q;
  logic [15:0]      rem_q, den_q;
  logic [QUO_W-1:0] quo_q;
  logic             inhale_q;
  logic [3:0]       curve_q;
  logic [10:0]      x_q;
  logic [20:0]      sq_q;
  logic [30:0]      cube_q;
  logic [10:0]      path_q;
  logic [18:0]      prod_q;
  logic [7:0]       level_q;
  logic             strobe_q;

  // divider step
  logic [16:0] div_shift;
  logic        div_ge;
  logic [16:0] div_sub;

  assign div_shift = {rem_q, 1'b0};
  assign div_ge    = (div_shift >= {1'b0, den_q});
  assign div_sub   = div_shift - {1'b0, den_q};

  // phase from the first division
  logic [10:0] phase;
  logic [10:0] ex_sub;
  logic [10:0] ex_x;

  assign phase  = sat_q ? ONE_Q : {1'b0, quo_q};
  assign ex_sub = phase - HOLD_END;
  assign ex_x   = {ex_sub[9:0], 1'b0};

  assign status_o.inhale = (phase < INHALE_END);
  assign status_o.hold   = (phase < HOLD_END);

  // easing base: mirrored operand for the falling halves
  logic        x_hi;
  logic        use_r;
  logic [10:0] base;

  assign x_hi = (x_q >= HOLD_END);

  always_comb begin
    case (curve_q)
      CURVE_QUAD_OUT, CURVE_CUBIC_OUT, CURVE_SINE_OUT: use_r = 1'b1;
      CURVE_QUAD_INOUT, CURVE_CUBIC_INOUT, CURVE_SINE_INOUT: use_r = x_hi;
      default: use_r = 1'b0;
    endcase
  end

  assign base = use_r ? (ONE_Q - x_q) : x_q;

  // shared multiplier
  logic        neg;
  logic [7:0]  mag;
  logic [20:0] mul_a;
  logic [10:0] mul_b;
  logic [31:0] mul_p;

  assign neg = (min_level_q > max_level_q);
  assign mag = neg ? (min_level_q - max_level_q) : (max_level_q - min_level_q);

  always_comb begin
    case (cmd_i.op)
      OP_XDIV: begin
        mul_a = INHALE_RECIP;
        mul_b = phase;
      end
      OP_CUBE: begin
        mul_a = sq_q;
        mul_b = base;
      end
      OP_MAP: begin
        mul_a = 21'(path_q);
        mul_b = 11'(mag);
      end
      default: begin
        mul_a = 21'(base);
        mul_b = base;
      end
    endcase
  end

  assign mul_p = 32'(mul_a) * 32'(mul_b);

  // curve evaluation
  logic [11:0] sq_s10, sq_s9, cu_s20, cu_s18;
  logic [11:0] ease_raw;
  logic [10:0] ease_v;

  assign sq_s10 = 12'(sq_q >> 10);
  assign sq_s9  = 12'(sq_q >> 9);
  assign cu_s20 = 12'(cube_q >> 20);
  assign cu_s18 = 12'(cube_q >> 18);

  always_comb begin
    case (curve_q)
      CURVE_QUAD_IN, CURVE_SINE_IN: ease_raw = sq_s10;
      CURVE_QUAD_OUT, CURVE_SINE_OUT: ease_raw = 12'(ONE_Q) - sq_s10;
      CURVE_QUAD_INOUT, CURVE_SINE_INOUT: ease_raw = x_hi ? (12'(ONE_Q) - sq_s9) : sq_s9;
      CURVE_CUBIC_IN: ease_raw = cu_s20;
      CURVE_CUBIC_OUT: ease_raw = 12'(ONE_Q) - cu_s20;
      CURVE_CUBIC_INOUT: ease_raw = x_hi ? (12'(ONE_Q) - cu_s18) : cu_s18;
      default: ease_raw = 12'(x_q);
    endcase
  end

  assign ease_v = (ease_raw > 12'(ONE_Q)) ? ONE_Q : ease_raw[10:0];

  // level mapping
  logic [8:0] map_q;
  logic [9:0] lvl_w;
  logic [7:0] level_d;

  assign map_q = prod_q[18:10];
  assign lvl_w = neg ? (10'(min_level_q) - 10'(map_q)) : (10'(min_level_q) + 10'(map_q));

  always_comb begin
    if (zero_q) begin
      level_d = max_level_q;
    end else if (lvl_w[9]) begin
      level_d = '0;
    end else if (lvl_w > 10'd255) begin
      level_d = 8'd255;
    end else begin
      level_d = lvl_w[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q       <= PERIOD_RST;
      inhale_curve_q <= INHALE_RST;
      exhale_curve_q <= EXHALE_RST;
      min_level_q    <= MIN_LVL_RST;
      max_level_q    <= MAX_LVL_RST;
      last_q         <= LAST_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PERIOD:  period_q       <= cfg_data_i;
          REG_INHALE:  inhale_curve_q <= cfg_data_i[3:0];
          REG_EXHALE:  exhale_curve_q <= cfg_data_i[3:0];
          REG_MIN_LVL: min_level_q    <= cfg_data_i[7:0];
          REG_MAX_LVL: max_level_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_LEVEL && level_d != last_q) begin
        last_q <= level_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        zero_q <= (period_q == '0);
        sat_q  <= (elapsed_ms_i >= period_q);
        rem_q  <= elapsed_ms_i;
        den_q  <= period_q;
        quo_q  <= '0;
      end
      OP_DIV: begin
        rem_q <= div_ge ? div_sub[15:0] : div_shift[15:0];
        quo_q <= {quo_q[QUO_W-2:0], div_ge};
      end
      OP_PHASE: begin
        inhale_q <= status_o.inhale;
        curve_q  <= status_o.inhale ? inhale_curve_q : exhale_curve_q;
        path_q   <= ONE_Q;
        x_q      <= ex_x;
      end
      OP_XDIV: begin
        x_q <= 11'(mul_p >> INHALE_SHIFT);
      end
      OP_SQ: begin
        sq_q <= mul_p[20:0];
      end
      OP_CUBE: begin
        cube_q <= mul_p[30:0];
      end
      OP_EASE: begin
        path_q <= inhale_q ? ease_v : (ONE_Q - ease_v);
      end
      OP_MAP: begin
        prod_q <= mul_p[18:0];
      end
      OP_LEVEL: begin
        level_q  <= level_d;
        strobe_q <= (level_d != last_q);
      end
      default: ;
    endcase
  end

  assign level_o        = level_q;
  assign write_strobe_o = strobe_q;

endmodule

[rtl/breathing_brightness_curve.sv]
// Breathing brightness curve. Each input beat carries the elapsed time within one
// breathing period; the block turns it into a backlight level and a write strobe
// that is high when the level differs from the last level flagged for writing
// (255 after reset). The phase is elapsed * 1024 / period, saturated at 1024; the
// first 40% eases up with the inhale curve, 40%..50% holds at max_level, and the
// rest eases down with the exhale curve. The path is mapped linearly from
// min_level to max_level; a zero period gives max_level. Registers are written
// through cfg_we_i / cfg_idx_i / cfg_data_i: 0 period_ms, 1 inhale_curve,
// 2 exhale_curve, 3 min_level, 4 max_level. The user must write them only while
// the block is idle; the block itself does not enforce this. One item is worked
// at a time: the restoring divider yields one quotient bit per cycle (ten for
// the phase), followed by the shared multiplier used for the inhale sub-phase
// (a reciprocal multiply by 1024 / 410), square, cube and level, and the next
// item is taken once the block is back in idle.
// The result sits in an output register, so a new item is taken while it waits.
module breathing_brightness_curve (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bbc_in_if.sink                         in_i,
  bbc_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bbc_pkg::*;

  bbc_cmd_t    cmd;
  bbc_status_t status;

  // sequence the phase division, easing and mapping steps
  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // registers, divider, multiplier and result payload
  bbc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .elapsed_ms_i   (in_i.elapsed_ms),
    .cmd_i          (cmd),
    .status_o       (status),
    .level_o        (out_o.level),
    .write_strobe_o (out_o.write_strobe)
  );

endmodule

[test/breathing_brightness_curve_tb.sv]
`timescale 1ns / 100ps

module breathing_brightness_curve_tb;
  import bbc_pkg::*;

  // Fixed-point phase marks, 1.0 == 1024
  localparam int unsigned FULL_SCALE   = 1024;
  localparam int unsigned INHALE_LIMIT = 410;
  localparam int unsigned HOLD_LIMIT   = 512;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int PHASES          = 20;
  localparam int PHASE_ITEMS     = 32;

  // Codes 10..15 are not in the curve list and must behave as linear
  localparam logic [3:0] CURVE_UNLISTED = 4'd15;

  // Elapsed times around the phase boundaries of the reset period (6000 ms)
  localparam logic [15:0] RESET_SWEEP [12] = '{
    16'd0, 16'd1, 16'd2400, 16'd2402, 16'd2403, 16'd2999,
    16'd3000, 16'd4500, 16'd6000, 16'd6001, 16'hFFFF, 16'hFFFF
  };
  localparam logic [15:0] PERIOD_EXTREMES [4] = '{16'd0, 16'd1, 16'hFFFF, 16'd0};

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  // Tracks the block's registers and last written level, predicts each
  // result beat in acceptance order and compares it with the output.
  class brightness_scoreboard;
    typedef struct {
      logic [7:0] level;
      logic       strobe;
    } level_beat_t;

    level_beat_t expected_levels[$];
    logic [15:0] period;
    logic [3:0]  inhale_curve;
    logic [3:0]  exhale_curve;
    logic [7:0]  min_level;
    logic [7:0]  max_level;
    logic [7:0]  last_written;
    int          errors;

    function new();
      period       = 16'd6000;
      inhale_curve = CURVE_QUAD_IN;
      exhale_curve = CURVE_QUAD_OUT;
      min_level    = 8'd80;
      max_level    = 8'd120;
      last_written = 8'd255;
      errors       = 0;
    endfunction

    function void flag_error(input string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PERIOD:  period = data;
        REG_INHALE:  inhale_curve = data[3:0];
        REG_EXHALE:  exhale_curve = data[3:0];
        REG_MIN_LVL: min_level = data[7:0];
        REG_MAX_LVL: max_level = data[7:0];
        default: ;
      endcase
    endfunction

    function longint unsigned ease(input longint unsigned x, input logic [3:0] curve);
      longint unsigned r;
      longint unsigned v;
      r = FULL_SCALE - x;
      case (curve)
        CURVE_QUAD_IN, CURVE_SINE_IN:   v = x * x / 1024;
        CURVE_QUAD_OUT, CURVE_SINE_OUT: v = 1024 - r * r / 1024;
        CURVE_QUAD_INOUT:  v = (x < 512) ? x * x * 2 / 1024 : 1024 - r * r * 2 / 1024;
        CURVE_CUBIC_IN:    v = x * x * x / (1024 * 1024);
        CURVE_CUBIC_OUT:   v = 1024 - r * r * r / (1024 * 1024);
        CURVE_CUBIC_INOUT: v = (x < 512) ? x * x * x * 4 / (1024 * 1024)
                                         : 1024 - r * r * r * 4 / (1024 * 1024);
        CURVE_SINE_INOUT:  v = (x < 512) ? x * x / 512 : 1024 - r * r / 512;
        default:           v = x;
      endcase
      if (v > FULL_SCALE) v = FULL_SCALE;
      return v;
    endfunction

    function void note_elapsed(input logic [15:0] elapsed);
      int unsigned     phase;
      int unsigned     sub_phase;
      longint unsigned path;
      int              level;
      level_beat_t     beat;
      if (period == 16'd0) begin
        level = int'(max_level);
      end else begin
        phase = ({16'd0, elapsed} * FULL_SCALE) / period;
        if (phase > FULL_SCALE) phase = FULL_SCALE;
        if (phase < INHALE_LIMIT) begin
          path = ease(phase * FULL_SCALE / INHALE_LIMIT, inhale_curve);
        end else if (phase < HOLD_LIMIT) begin
          path = FULL_SCALE;
        end else begin
          sub_phase = (phase - HOLD_LIMIT) * FULL_SCALE / HOLD_LIMIT;
          if (sub_phase > FULL_SCALE) sub_phase = FULL_SCALE;
          path = FULL_SCALE - ease(sub_phase, exhale_curve);
        end
        level = int'(min_level) + ((int'(max_level) - int'(min_level)) * int'(path)) / 1024;
      end
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      beat.level  = 8'(level);
      beat.strobe = (beat.level != last_written);
      if (beat.strobe) last_written = beat.level;
      expected_levels.push_back(beat);
    endfunction

    function void check_beat(input logic [7:0] level, input logic strobe);
      level_beat_t beat;
      if (expected_levels.size() == 0) begin
        flag_error($sformatf("unexpected result beat: expected none, got level=%0d strobe=%0b",
                             level, strobe));
        return;
      end
      beat = expected_levels.pop_front();
      if (level !== beat.level)
        flag_error($sformatf("level mismatch: expected %0d, got %0d", beat.level, level));
      if (strobe !== beat.strobe)
        flag_error($sformatf("write_strobe mismatch: expected %0b, got %0b (level %0d)",
                             beat.strobe, strobe, beat.level));
    endfunction

    function int outstanding();
      return expected_levels.size();
    endfunction

    function void flag_leftover();
      if (expected_levels.size() != 0)
        flag_error($sformatf("missing results: expected %0d more beats, got none",
                             expected_levels.size()));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bbc_in_if  in_if ();
  bbc_out_if out_if ();

  brightness_scoreboard sb;

  // Receiver controls, set by the main sequence
  rx_mode_e rx_mode;
  int       rx_period;
  int       rx_tick;
  logic     long_hold_req;
  int       cycle_count = 0;

  breathing_brightness_curve dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 0;
  end

  // Bound the run; a hang or a lost beat ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every result beat accepted by the receiver against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_beat(out_if.level, out_if.write_strobe);
  end

  // Receiver: drive ready from the current stall pattern. On a hold-off
  // request, drop ready for a long, counted stretch so the output register
  // and the working item both fill and the input side backs up.
  initial begin
    out_if.ready <= 1'b0;
    rx_tick = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_if.ready <= 1'b1;
          RX_RANDOM: out_if.ready <= ($urandom_range(0, 99) < 60);
          default: begin
            rx_tick++;
            out_if.ready <= (rx_tick % rx_period) != 0;
          end
        endcase
      end
    end
  end

  // Offer one beat and hold it until accepted; leave valid high so the
  // next beat of a burst can follow back to back.
  task automatic send_item(input logic [15:0] elapsed);
    in_if.valid      <= 1'b1;
    in_if.elapsed_ms <= elapsed;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_elapsed(elapsed);
  endtask

  // Idle the sender when n is positive; scramble the payload while valid is low
  task automatic pause_tx(input int n);
    if (n > 0) begin
      in_if.valid      <= 1'b0;
      in_if.elapsed_ms <= 16'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted beat has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all five registers; fill the unused upper data bits with noise
  task automatic apply_setting(input logic [15:0] per, input logic [3:0] rise,
                               input logic [3:0] fall, input logic [7:0] lo,
                               input logic [7:0] hi);
    cfg_write(REG_PERIOD, per);
    cfg_write(REG_INHALE, {12'($urandom), rise});
    cfg_write(REG_EXHALE, {12'($urandom), fall});
    cfg_write(REG_MIN_LVL, {8'($urandom), lo});
    cfg_write(REG_MAX_LVL, {8'($urandom), hi});
  endtask

  // Mostly times within one period (plus a little overshoot), some right at
  // the inhale, hold and end marks, some anywhere in the 16-bit range.
  function automatic logic [15:0] pick_elapsed();
    int unsigned span;
    int unsigned mark;
    int unsigned frac;
    if (sb.period == 16'd0) return 16'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 2))
          0:       frac = INHALE_LIMIT;
          1:       frac = HOLD_LIMIT;
          default: frac = FULL_SCALE;
        endcase
        mark = sb.period * frac / FULL_SCALE + $urandom_range(0, 4);
        mark = (mark >= 2) ? mark - 2 : 0;
        if (mark > 65535) mark = 65535;
        return 16'(mark);
      end
      default: begin
        span = sb.period + sb.period / 8;
        if (span > 65535) span = 65535;
        return 16'($urandom_range(0, span));
      end
    endcase
  endfunction

  // Send count beats in bursts of random length, with random gaps between them
  task automatic run_items(input int count, input int max_gap);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_item(pick_elapsed());
        burst--;
        left--;
      end
      if (max_gap > 0) pause_tx($urandom_range(1, max_gap));
    end
  endtask

  initial begin
    logic [15:0] per;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  swap;
    int          gap_max;

    sb = new();
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.elapsed_ms <= 16'd0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_PERIOD;
    cfg_data_i       <= 16'd0;
    rx_mode       = RX_ALWAYS;
    rx_period     = 4;
    long_hold_req = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: walk the start, the inhale/hold edge, the hold/exhale
    // edge, the end of the period and beyond it. The repeated last time
    // must come back without a strobe.
    foreach (RESET_SWEEP[i]) send_item(RESET_SWEEP[i]);
    drain();

    // Zero period: any time gives max_level
    apply_setting(16'd0, CURVE_CUBIC_IN, CURVE_CUBIC_OUT, 8'd30, 8'd200);
    send_item(16'd12345);
    send_item(16'd0);
    drain();

    // Min above max maps downward; an unlisted exhale curve acts as linear;
    // a write to an index past the register list changes nothing
    apply_setting(16'd1000, CURVE_LINEAR, CURVE_UNLISTED, 8'd200, 8'd10);
    cfg_write(REG_MAX_LVL + 3'd1, 16'hFFFF);
    send_item(16'd0);
    send_item(16'd200);
    send_item(16'd450);
    send_item(16'd700);
    send_item(16'd1000);
    drain();

    // Both levels at the top: every path lands on 255
    apply_setting(16'd1000, CURVE_SINE_INOUT, CURVE_QUAD_INOUT, 8'd255, 8'd255);
    send_item(16'd100);
    send_item(16'd800);

    // Random phases: step both curves through every code, rotate the period
    // through small, mid, full-range, large and extreme values, and vary the levels
    // between random, full swing, inverted full swing and inverted random.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 5)
        0:       per = 16'($urandom_range(1, 200));
        1:       per = 16'($urandom_range(200, 8000));
        2:       per = 16'($urandom);
        3:       per = PERIOD_EXTREMES[ph / 5];
        default: per = 16'($urandom_range(8000, 65535));
      endcase
      case (ph % 4)
        0: begin
          lo = 8'($urandom);
          hi = 8'($urandom);
        end
        1: begin
          lo = 8'd0;
          hi = 8'd255;
        end
        2: begin
          lo = 8'd255;
          hi = 8'd0;
        end
        default: begin
          lo = 8'($urandom);
          hi = 8'($urandom);
          if (lo < hi) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
          end
        end
      endcase
      apply_setting(per, 4'(ph % 16), 4'((ph * 5 + 2) % 16), lo, hi);
      if (ph % 3 == 0) cfg_write(REG_MAX_LVL + 3'($urandom_range(1, 3)), 16'($urandom));

      // Vary the receiver's stall pattern; every fourth phase the sender runs
      // with no gaps at all
      rx_mode   = rx_mode_e'(ph % 3);
      rx_period = $urandom_range(2, 6);
      gap_max   = (ph % 4 == 0) ? 0 : $urandom_range(2, 12);

      // Block the receiver for a long stretch while the sender keeps offering
      if (ph == 5 || ph == 14) long_hold_req = 1'b1;

      // Odd phases: stop halfway and let everything come back before going on
      if (ph % 2 == 1) begin
        run_items(PHASE_ITEMS / 2, gap_max);
        drain();
        run_items(PHASE_ITEMS / 2, gap_max);
      end else begin
        run_items(PHASE_ITEMS, gap_max);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bbc_pkg.sv
rtl/bbc_in_if.sv
rtl/bbc_out_if.sv
rtl/bbc_ctrl.sv
rtl/bbc_dpath.sv
rtl/breathing_brightness_curve.sv
test/breathing_brightness_curve_tb.sv
